/* rtl/cha_pkg.sv */
// Shared constants of the convex hull area block.
package cha_pkg;

    // Width of the doubled-area result field.
    localparam int AREA_W = 33;

    // Width of the hull vertex count field.
    localparam int VERT_W = 7;

    // Cycles from turn operands to the registered cross product.
    localparam int TURN_LAT = 3;

endpackage

/* rtl/cha_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module cha_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/cha_turn.sv */
// Pipelined exact cross product (b - a) x (c - a) over three stages.
module cha_turn #(
    parameter int COORD_BITS = 16
) (
    input  logic                          i_clk,
    input  logic signed [COORD_BITS-1:0]  i_a_x,
    input  logic signed [COORD_BITS-1:0]  i_a_y,
    input  logic signed [COORD_BITS-1:0]  i_b_x,
    input  logic signed [COORD_BITS-1:0]  i_b_y,
    input  logic signed [COORD_BITS-1:0]  i_c_x,
    input  logic signed [COORD_BITS-1:0]  i_c_y,
    output logic signed [2*COORD_BITS+2:0] o_cross
);

    localparam int DW = COORD_BITS + 1;
    localparam int MW = 2 * COORD_BITS + 2;
    localparam int XW = 2 * COORD_BITS + 3;

    logic signed [DW-1:0] r_d1x, r_d1y, r_d2x, r_d2y;
    logic signed [MW-1:0] r_p1, r_p2;
    logic signed [XW-1:0] r_cross;

    // Stage one: edge vectors; stage two: products; stage three: difference.
    always_ff @(posedge i_clk) begin
        r_d1x   <= {i_b_x[COORD_BITS-1], i_b_x} - {i_a_x[COORD_BITS-1], i_a_x};
        r_d1y   <= {i_b_y[COORD_BITS-1], i_b_y} - {i_a_y[COORD_BITS-1], i_a_y};
        r_d2x   <= {i_c_x[COORD_BITS-1], i_c_x} - {i_a_x[COORD_BITS-1], i_a_x};
        r_d2y   <= {i_c_y[COORD_BITS-1], i_c_y} - {i_a_y[COORD_BITS-1], i_a_y};
        r_p1    <= r_d1x * r_d2y;
        r_p2    <= r_d1y * r_d2x;
        r_cross <= {r_p1[MW-1], r_p1} - {r_p2[MW-1], r_p2};
    end

    assign o_cross = r_cross;

endmodule

/* rtl/convex_hull_area.sv */
// Convex hull area: Graham scan over stored points, shoelace area of the hull.
// Loading takes one point word per cycle while o_ready is high; the last word starts the computation.
// Steps in order: pivot swap, insertion sort by angle, the scan with its turn tests,
// pushes and pops, the area as one fan triangle per hull edge, then the output register;
// the sort, the scan and the area are paced by the three-stage cross product.
// Reset is synchronous, active low, and clears the control state only.
module convex_hull_area #(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic signed [COORD_BITS-1:0]     i_point_x,
    input  logic signed [COORD_BITS-1:0]     i_point_y,
    input  logic                             i_last_point,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [cha_pkg::AREA_W-1:0]       o_area_doubled,
    output logic [cha_pkg::VERT_W-1:0]       o_hull_vertices,
    output logic                             o_overflowed
);

    localparam int C   = COORD_BITS;
    localparam int PW  = 2 * COORD_BITS;
    localparam int XW  = 2 * COORD_BITS + 3;
    localparam int AW  = 2 * COORD_BITS + 4;
    localparam int IW  = $clog2(MAX_POINTS);
    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int WW  = $clog2(cha_pkg::TURN_LAT + 1);

    typedef enum logic [4:0] {
        S_LOAD, S_SWAP_RD, S_SWAP_WR0, S_SWAP_WR1,
        S_SORT_RD, S_SORT_TMP, S_SORT_CMP, S_SORT_Q, S_SORT_WAIT, S_SORT_NEXT,
        S_SCAN_RD1, S_SCAN_INIT, S_SCAN_RD, S_SCAN_CUR, S_SCAN_TEST, S_SCAN_WAIT,
        S_SCAN_SEC, S_AREA_RD, S_AREA_B, S_AREA_C, S_AREA_WAIT, S_DONE
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count, r_i, n_i, r_j, n_j, r_d, n_d, r_k, n_k;
    logic          r_drop, n_drop, r_less, n_less;
    logic signed [C-1:0] r_pivx, n_pivx, r_pivy, n_pivy;
    logic [IW-1:0] r_pidx, n_pidx;
    logic [PW-1:0] r_tmp, n_tmp, r_q, n_q, r_cur, n_cur, r_top, n_top, r_sec, n_sec;
    logic [PW-1:0] r_ta, n_ta, r_tb, n_tb, r_tc, n_tc;
    logic [WW-1:0] r_wait, n_wait;
    logic [AW-1:0] r_acc, n_acc;
    logic          r_ovalid, n_ovalid, r_oovf, n_oovf;
    logic [cha_pkg::AREA_W-1:0] r_oarea, n_oarea;
    logic [cha_pkg::VERT_W-1:0] r_overt, n_overt;

    logic          p_we, s_we;
    logic [IW-1:0] p_waddr, p_raddr, s_waddr, s_raddr;
    logic [PW-1:0] p_wdata, p_rdata, s_wdata, s_rdata;
    logic signed [XW-1:0] t_cross;
    logic [CW-1:0] jm1, dm1, dm3, kp1, kp2;
    logic signed [C-1:0] rd_x, rd_y, tmp_x, tmp_y;

    // Point store and hull stack, both holding packed {y, x} coordinates.
    cha_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_points (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(p_waddr), .i_wdata(p_wdata),
        .i_raddr(p_raddr), .o_rdata(p_rdata)
    );

    cha_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_stack (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_raddr(s_raddr), .o_rdata(s_rdata)
    );

    // Shared cross product unit.
    cha_turn #(.COORD_BITS(COORD_BITS)) u_turn (
        .i_clk(i_clk),
        .i_a_x(r_ta[C-1:0]), .i_a_y(r_ta[PW-1:C]),
        .i_b_x(r_tb[C-1:0]), .i_b_y(r_tb[PW-1:C]),
        .i_c_x(r_tc[C-1:0]), .i_c_y(r_tc[PW-1:C]),
        .o_cross(t_cross)
    );

    assign jm1   = r_j - CW'(1);
    assign dm1   = r_d - CW'(1);
    assign dm3   = r_d - CW'(3);
    assign kp1   = r_k + CW'(1);
    assign kp2   = r_k + CW'(2);
    assign rd_x  = p_rdata[C-1:0];
    assign rd_y  = p_rdata[PW-1:C];
    assign tmp_x = r_tmp[C-1:0];
    assign tmp_y = r_tmp[PW-1:C];

    assign o_ready         = (r_state == S_LOAD);
    assign o_valid         = r_ovalid;
    assign o_area_doubled  = r_oarea;
    assign o_hull_vertices = r_overt;
    assign o_overflowed    = r_oovf;

    // Sequencer: next-state values and memory port control.
    always_comb begin
        n_state = r_state;  n_count = r_count; n_i = r_i;     n_j = r_j;
        n_d     = r_d;      n_k     = r_k;     n_drop = r_drop; n_less = r_less;
        n_pivx  = r_pivx;   n_pivy  = r_pivy;  n_pidx = r_pidx;
        n_tmp   = r_tmp;    n_q     = r_q;     n_cur  = r_cur;
        n_top   = r_top;    n_sec   = r_sec;
        n_ta    = r_ta;     n_tb    = r_tb;    n_tc   = r_tc;
        n_wait  = r_wait;   n_acc   = r_acc;
        n_oarea = r_oarea;  n_overt = r_overt; n_oovf = r_oovf;
        n_ovalid = r_ovalid;
        p_we = 1'b0; p_waddr = '0; p_wdata = '0; p_raddr = '0;
        s_we = 1'b0; s_waddr = '0; s_wdata = '0; s_raddr = '0;

        // The output register empties when its word is taken.
        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_LOAD: begin
                if (i_valid) begin
                    if (r_count < CW'(MAX_POINTS)) begin
                        p_we    = 1'b1;
                        p_waddr = r_count[IW-1:0];
                        p_wdata = {i_point_y, i_point_x};
                        // Track the lowest point, leftmost on ties.
                        if (r_count == '0 || i_point_y < r_pivy ||
                            (i_point_y == r_pivy && i_point_x < r_pivx)) begin
                            n_pivx = i_point_x;
                            n_pivy = i_point_y;
                            n_pidx = r_count[IW-1:0];
                        end
                        n_count = r_count + CW'(1);
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_last_point) begin
                        if (n_count <= CW'(2)) begin
                            n_d     = n_count;
                            n_acc   = '0;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_SWAP_RD;
                        end
                    end
                end
            end
            // Move the pivot into slot zero.
            S_SWAP_RD: begin
                p_raddr = '0;
                n_state = S_SWAP_WR0;
            end
            S_SWAP_WR0: begin
                p_we    = 1'b1;
                p_waddr = r_pidx;
                p_wdata = p_rdata;
                n_state = S_SWAP_WR1;
            end
            S_SWAP_WR1: begin
                p_we    = 1'b1;
                p_waddr = '0;
                p_wdata = {r_pivy, r_pivx};
                n_i     = CW'(2);
                n_state = S_SORT_RD;
            end
            // Insertion sort by angle about the pivot.
            S_SORT_RD: begin
                p_raddr = r_i[IW-1:0];
                n_state = S_SORT_TMP;
            end
            S_SORT_TMP: begin
                n_tmp   = p_rdata;
                n_j     = r_i;
                n_state = S_SORT_CMP;
            end
            S_SORT_CMP: begin
                if (r_j > CW'(1)) begin
                    p_raddr = jm1[IW-1:0];
                    n_state = S_SORT_Q;
                end else begin
                    p_we    = 1'b1;
                    p_waddr = r_j[IW-1:0];
                    p_wdata = r_tmp;
                    n_state = S_SORT_NEXT;
                end
            end
            S_SORT_Q: begin
                n_q  = p_rdata;
                n_ta = {r_pivy, r_pivx};
                n_tb = r_tmp;
                n_tc = p_rdata;
                // On one ray from the pivot, nearer means lower, then further left.
                n_less  = (tmp_y < rd_y) || (tmp_y == rd_y && tmp_x < rd_x);
                n_wait  = WW'(cha_pkg::TURN_LAT);
                n_state = S_SORT_WAIT;
            end
            S_SORT_WAIT: begin
                if (r_wait != '0) begin
                    n_wait = r_wait - WW'(1);
                end else if (t_cross > 0 || (t_cross == 0 && r_less)) begin
                    p_we    = 1'b1;
                    p_waddr = r_j[IW-1:0];
                    p_wdata = r_q;
                    n_j     = jm1;
                    n_state = S_SORT_CMP;
                end else begin
                    p_we    = 1'b1;
                    p_waddr = r_j[IW-1:0];
                    p_wdata = r_tmp;
                    n_state = S_SORT_NEXT;
                end
            end
            S_SORT_NEXT: begin
                n_i     = r_i + CW'(1);
                n_state = (r_i + CW'(1) < r_count) ? S_SORT_RD : S_SCAN_RD1;
            end
            // Scan: the stack starts with the pivot and the first sorted point.
            S_SCAN_RD1: begin
                p_raddr = IW'(1);
                s_we    = 1'b1;
                s_waddr = '0;
                s_wdata = {r_pivy, r_pivx};
                n_state = S_SCAN_INIT;
            end
            S_SCAN_INIT: begin
                s_we    = 1'b1;
                s_waddr = IW'(1);
                s_wdata = p_rdata;
                n_top   = p_rdata;
                n_sec   = {r_pivy, r_pivx};
                n_d     = CW'(2);
                n_i     = CW'(2);
                n_state = S_SCAN_RD;
            end
            S_SCAN_RD: begin
                if (r_i < r_count) begin
                    p_raddr = r_i[IW-1:0];
                    n_state = S_SCAN_CUR;
                end else if (r_d < CW'(3)) begin
                    n_acc   = '0;
                    n_state = S_DONE;
                end else begin
                    n_acc   = '0;
                    n_k     = CW'(1);
                    n_state = S_AREA_RD;
                end
            end
            S_SCAN_CUR: begin
                n_cur   = p_rdata;
                n_state = S_SCAN_TEST;
            end
            S_SCAN_TEST: begin
                if (r_d > CW'(1)) begin
                    n_ta    = r_sec;
                    n_tb    = r_top;
                    n_tc    = r_cur;
                    n_wait  = WW'(cha_pkg::TURN_LAT);
                    n_state = S_SCAN_WAIT;
                end else begin
                    s_we    = 1'b1;
                    s_waddr = r_d[IW-1:0];
                    s_wdata = r_cur;
                    n_sec   = r_top;
                    n_top   = r_cur;
                    n_d     = r_d + CW'(1);
                    n_i     = r_i + CW'(1);
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_WAIT: begin
                if (r_wait != '0) begin
                    n_wait = r_wait - WW'(1);
                end else if (t_cross <= 0) begin
                    // Not a strict left turn: pop the top entry.
                    n_d   = dm1;
                    n_top = r_sec;
                    if (r_d > CW'(2)) begin
                        s_raddr = dm3[IW-1:0];
                        n_state = S_SCAN_SEC;
                    end else begin
                        n_state = S_SCAN_TEST;
                    end
                end else begin
                    s_we    = 1'b1;
                    s_waddr = r_d[IW-1:0];
                    s_wdata = r_cur;
                    n_sec   = r_top;
                    n_top   = r_cur;
                    n_d     = r_d + CW'(1);
                    n_i     = r_i + CW'(1);
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_SEC: begin
                n_sec   = s_rdata;
                n_state = S_SCAN_TEST;
            end
            // Shoelace area as a fan of triangles from the pivot.
            S_AREA_RD: begin
                s_raddr = r_k[IW-1:0];
                n_state = S_AREA_B;
            end
            S_AREA_B: begin
                n_tb    = s_rdata;
                s_raddr = kp1[IW-1:0];
                n_state = S_AREA_C;
            end
            S_AREA_C: begin
                n_ta    = {r_pivy, r_pivx};
                n_tc    = s_rdata;
                n_wait  = WW'(cha_pkg::TURN_LAT);
                n_state = S_AREA_WAIT;
            end
            S_AREA_WAIT: begin
                if (r_wait != '0) begin
                    n_wait = r_wait - WW'(1);
                end else begin
                    n_acc   = r_acc + {{(AW-XW){t_cross[XW-1]}}, t_cross};
                    n_k     = kp1;
                    n_state = (kp2 < r_d) ? S_AREA_RD : S_DONE;
                end
            end
            // Hand the result to the output register once it is free.
            S_DONE: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_oarea  = r_acc[cha_pkg::AREA_W-1:0];
                    n_overt  = cha_pkg::VERT_W'(r_d);
                    n_oovf   = r_drop;
                    n_count  = '0;
                    n_drop   = 1'b0;
                    n_state  = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_count  <= '0;
            r_drop   <= 1'b0;
            r_ovalid <= 1'b0;
            r_wait   <= '0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_drop   <= n_drop;
            r_ovalid <= n_ovalid;
            r_wait   <= n_wait;
        end
        r_i <= n_i;       r_j <= n_j;       r_d <= n_d;       r_k <= n_k;
        r_less <= n_less; r_pivx <= n_pivx; r_pivy <= n_pivy; r_pidx <= n_pidx;
        r_tmp <= n_tmp;   r_q <= n_q;       r_cur <= n_cur;
        r_top <= n_top;   r_sec <= n_sec;
        r_ta <= n_ta;     r_tb <= n_tb;     r_tc <= n_tc;
        r_acc <= n_acc;
        r_oarea <= n_oarea; r_overt <= n_overt; r_oovf <= n_oovf;
    end

endmodule

/* rtl/cha_checker.sv */
// Port-level checks of the convex hull area block and their binding.
module cha_checker #(
    parameter int COORD_BITS = 16
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_ready,
    input logic signed [COORD_BITS-1:0]  i_point_x,
    input logic signed [COORD_BITS-1:0]  i_point_y,
    input logic                          i_last_point,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [cha_pkg::AREA_W-1:0]    o_area_doubled,
    input logic [cha_pkg::VERT_W-1:0]    o_hull_vertices,
    input logic                          o_overflowed
);

    // No result word is presented right after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // A stalled result word holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_area_doubled) &&
        $stable(o_hull_vertices) && $stable(o_overflowed))
        else $error("stalled result changed");

    // A point word waiting for intake holds.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_point_x) &&
        $stable(i_point_y) && $stable(i_last_point))
        else $error("waiting point word changed");

    // Closing a set stops intake until the hull is done.
    a_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_last_point |=> !o_ready)
        else $error("input taken while computing");

    // A hull with fewer than three vertices has no area.
    a_small: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hull_vertices < 3 |-> o_area_doubled == 0)
        else $error("area reported for degenerate hull");

endmodule

bind convex_hull_area cha_checker #(.COORD_BITS(COORD_BITS)) u_cha_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .i_point_x(i_point_x), .i_point_y(i_point_y), .i_last_point(i_last_point),
    .o_valid(o_valid), .i_ready(i_ready), .o_area_doubled(o_area_doubled),
    .o_hull_vertices(o_hull_vertices), .o_overflowed(o_overflowed)
);

/* tb/tb_convex_hull_area.sv */
// Testbench for the convex hull area block: directed and random point sets checked against a scoreboard.
`timescale 1ns / 1ps

// Scoreboard: collects the points of each set and predicts the hull result.
class hull_scoreboard;
    longint xs[$];
    longint ys[$];
    bit dropped;
    logic [cha_pkg::AREA_W-1:0] exp_area[$];
    logic [cha_pkg::VERT_W-1:0] exp_verts[$];
    bit exp_ovf[$];
    int errors;
    int sets_done;
    int max_seen;

    function new();
        errors = 0;
        sets_done = 0;
        max_seen = 0;
        dropped = 0;
    endfunction

    function longint cross3(longint ax, longint ay, longint bx, longint by,
                            longint cx, longint cy);
        return (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
    endfunction

    // Notes one accepted point word; a closing word queues a prediction.
    function void note_point(logic signed [15:0] px, logic signed [15:0] py, bit last);
        longint px_l[$];
        longint py_l[$];
        int stk[$];
        int n, piv, i, j;
        longint tx, ty, c, da, db, sum;
        bit goes;
        if (xs.size() < 64) begin
            xs.insert(xs.size(), longint'(px));
            ys.insert(ys.size(), longint'(py));
        end else begin
            dropped = 1;
        end
        if (!last) return;
        n = xs.size();
        sum = 0;
        if (n <= 2) begin
            exp_verts.insert(exp_verts.size(), n[6:0]);
        end else begin
            px_l = xs;
            py_l = ys;
            // Lowest point, leftmost on ties, moves to the front.
            piv = 0;
            for (i = 1; i < n; i++)
                if (py_l[i] < py_l[piv] || (py_l[i] == py_l[piv] && px_l[i] < px_l[piv]))
                    piv = i;
            tx = px_l[0]; ty = py_l[0];
            px_l[0] = px_l[piv]; py_l[0] = py_l[piv];
            px_l[piv] = tx; py_l[piv] = ty;
            // Insertion sort by angle, nearest first on the same ray.
            for (i = 2; i < n; i++) begin
                tx = px_l[i]; ty = py_l[i];
                j = i;
                while (j > 1) begin
                    c = cross3(px_l[0], py_l[0], tx, ty, px_l[j-1], py_l[j-1]);
                    if (c == 0) begin
                        da = (tx-px_l[0])*(tx-px_l[0]) + (ty-py_l[0])*(ty-py_l[0]);
                        db = (px_l[j-1]-px_l[0])*(px_l[j-1]-px_l[0])
                           + (py_l[j-1]-py_l[0])*(py_l[j-1]-py_l[0]);
                        goes = da < db;
                    end else begin
                        goes = c > 0;
                    end
                    if (!goes) break;
                    px_l[j] = px_l[j-1]; py_l[j] = py_l[j-1];
                    j--;
                end
                px_l[j] = tx; py_l[j] = ty;
            end
            // Scan pops while the turn is not strictly left.
            stk.insert(stk.size(), 0);
            stk.insert(stk.size(), 1);
            for (i = 2; i < n; i++) begin
                while (stk.size() > 1 &&
                       cross3(px_l[stk[stk.size()-2]], py_l[stk[stk.size()-2]],
                              px_l[stk[stk.size()-1]], py_l[stk[stk.size()-1]],
                              px_l[i], py_l[i]) <= 0)
                    stk.delete(stk.size() - 1);
                stk.insert(stk.size(), i);
            end
            if (stk.size() >= 3)
                for (i = 1; i + 1 < stk.size(); i++)
                    sum += cross3(px_l[stk[0]], py_l[stk[0]], px_l[stk[i]], py_l[stk[i]],
                                  px_l[stk[i+1]], py_l[stk[i+1]]);
            if (sum < 0) sum = -sum;
            exp_verts.insert(exp_verts.size(), 7'(stk.size()));
        end
        exp_area.insert(exp_area.size(), sum[32:0]);
        exp_ovf.insert(exp_ovf.size(), dropped);
        if (n > max_seen) max_seen = n;
        xs.delete();
        ys.delete();
        dropped = 0;
    endfunction

    // Checks one accepted result word against the oldest prediction.
    function void check_result(logic [32:0] area, logic [6:0] verts, bit ovf);
        if (exp_area.size() == 0) begin
            $display("%0t: unexpected result area=%0d verts=%0d ovf=%0b",
                     $realtime, area, verts, ovf);
            errors++;
            return;
        end
        if (area !== exp_area[0]) begin
            $display("%0t: area mismatch expected %0d actual %0d", $realtime,
                     exp_area[0], area);
            errors++;
        end
        if (verts !== exp_verts[0]) begin
            $display("%0t: vertex count mismatch expected %0d actual %0d", $realtime,
                     exp_verts[0], verts);
            errors++;
        end
        if (ovf !== exp_ovf[0]) begin
            $display("%0t: overflow flag mismatch expected %0b actual %0b", $realtime,
                     exp_ovf[0], ovf);
            errors++;
        end
        void'(exp_area.pop_front());
        void'(exp_verts.pop_front());
        void'(exp_ovf.pop_front());
        sets_done++;
    endfunction

    function int pending();
        return exp_area.size();
    endfunction
endclass

module tb_convex_hull_area;
    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    logic signed [15:0] i_point_x;
    logic signed [15:0] i_point_y;
    logic i_last_point;
    logic o_valid;
    logic i_ready;
    logic [cha_pkg::AREA_W-1:0] o_area_doubled;
    logic [cha_pkg::VERT_W-1:0] o_hull_vertices;
    logic o_overflowed;

    hull_scoreboard board;
    longint cycle_count;
    int gap_pct;
    int words_sent;

    convex_hull_area DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_point_x(i_point_x), .i_point_y(i_point_y), .i_last_point(i_last_point),
        .o_valid(o_valid), .i_ready(i_ready), .o_area_doubled(o_area_doubled),
        .o_hull_vertices(o_hull_vertices), .o_overflowed(o_overflowed)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        board = new();
        i_rst_n = 0;
        i_valid = 0;
        i_point_x = 0;
        i_point_y = 0;
        i_last_point = 0;
        i_ready = 0;
        gap_pct = 20;
        words_sent = 0;
    end

    // Cycle counter with a hard limit on the run.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > 3000000) begin
                $display("timeout after %0d cycles", cycle_count);
                $display("convex_hull_area test failed");
                $finish;
            end
        end
    end

    // Receiver side: random stalls, checks every accepted word.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            board.check_result(o_area_doubled, o_hull_vertices, o_overflowed);
        i_ready <= ($urandom_range(99) >= gap_pct);
    end

    // Sends one point word, with an optional random gap before it.
    // Valid stays high after acceptance until the next gap or pause drops it.
    task automatic send_point(input logic signed [15:0] px, input logic signed [15:0] py,
                              input bit last);
        while ($urandom_range(99) < gap_pct) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_point_x <= px;
        i_point_y <= py;
        i_last_point <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        board.note_point(px, py, last);
        words_sent++;
    endtask

    function automatic logic signed [15:0] rand_coord(int span);
        case ($urandom_range(9))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'($urandom);
            default: return 16'($signed($urandom_range(2 * span)) - span);
        endcase
    endfunction

    // Sends a random set of the given size.
    task automatic send_set(int n, int span);
        for (int k = 0; k < n; k++)
            send_point(rand_coord(span), rand_coord(span), k == n - 1);
    endtask

    initial begin
        int n;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed sets: single point, pair, collinear, duplicates, square, extremes.
        send_point(16'sd5, -16'sd3, 1);
        send_point(16'sd1, 16'sd1, 0);
        send_point(16'sd4, 16'sd2, 1);
        send_point(16'sd0, 16'sd0, 0);
        send_point(16'sd2, 16'sd2, 0);
        send_point(16'sd1, 16'sd1, 1);
        send_point(16'sd3, 16'sd3, 0);
        send_point(16'sd3, 16'sd3, 0);
        send_point(16'sd3, 16'sd3, 1);
        send_point(16'sd0, 16'sd0, 0);
        send_point(16'sd4, 16'sd0, 0);
        send_point(16'sd4, 16'sd4, 0);
        send_point(16'sd0, 16'sd4, 0);
        send_point(16'sd2, 16'sd2, 1);
        send_point(16'sh8000, 16'sh8000, 0);
        send_point(16'sh7fff, 16'sh8000, 0);
        send_point(16'sh7fff, 16'sh7fff, 0);
        send_point(16'sh8000, 16'sh7fff, 1);

        // Wait for all results before moving on.
        i_valid <= 0;
        while (board.pending() != 0) @(posedge i_clk);

        // Capacity: 70 points, the last six dropped, the last one still closing the set.
        send_set(70, 1000);
        // Full capacity exactly.
        send_set(64, 30000);

        // Random sets, mostly small; one stretch with no idling.
        while (words_sent < 1070) begin
            gap_pct = (words_sent > 500 && words_sent < 700) ? 0 : 20;
            case ($urandom_range(19))
                0: n = $urandom_range(65, 68);
                1: n = $urandom_range(1, 2);
                default: n = $urandom_range(3, 16);
            endcase
            send_set(n, ($urandom_range(1)) ? 20 : 32767);
        end

        i_valid <= 0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("Sent %0d point words in %0d sets, up to %0d stored points per set.",
                 words_sent, board.sets_done, board.max_seen);
        $display("Sets covered singles, pairs, collinear, duplicate and overflowing inputs.");
        if (board.errors == 0 && board.pending() == 0)
            $display("convex_hull_area test passed");
        else
            $display("convex_hull_area test failed");
        $finish;
    end
endmodule

/* files.f */
rtl/cha_pkg.sv
rtl/cha_ram.sv
rtl/cha_turn.sv
rtl/convex_hull_area.sv
rtl/cha_checker.sv
tb/tb_convex_hull_area.sv
